>>> src/cbra_pkg.sv
// Shared types, codes and defaults for the cluster bitmap run allocator.
package cbra_pkg;

    localparam int MAP_BYTES_DEF = 128;
    localparam int MAX_RUN_DEF   = 32;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_ALLOC = 2'd2;
    localparam logic [1:0] OP_FREE  = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [6:0]  byte_index;
        logic [7:0]  byte_value;
        logic [10:0] request_clusters;
        logic [9:0]  run_start;
        logic [5:0]  run_length;
    } t_request;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [9:0]  found_start;
        logic [5:0]  found_length;
        logic [10:0] free_clusters;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ_A,
        S_READ_B,
        S_SCAN,
        S_SCAN_END,
        S_RMW_RD,
        S_RMW_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic read_cap;
        logic scan;
        logic scan_fin;
        logic rmw_wr;
    } t_dp_cmd;

    typedef struct packed {
        logic req_skip;
        logic scan_end;
        logic fin_empty;
        logic rmw_last;
    } t_dp_sts;

endpackage

>>> src/cbra_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cbra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/cbra_ctrl.sv
// Controller state machine sequencing load, read, allocate and free requests.
module cbra_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [1:0]        i_operation,
    input  cbra_pkg::t_dp_sts i_sts,
    output cbra_pkg::t_dp_cmd o_cmd,
    output logic              o_busy,
    output logic              o_done
);
    import cbra_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        o_done  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    if (i_sts.req_skip) begin
                        n_state = S_DONE;
                    end else if (i_operation == OP_READ) begin
                        n_state = S_READ_A;
                    end else if (i_operation == OP_ALLOC) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_RMW_RD;
                    end
                end
            end
            S_READ_A: begin
                n_state = S_READ_B;
            end
            S_READ_B: begin
                o_cmd.read_cap = 1'b1;
                n_state        = S_DONE;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_end) begin
                    n_state = S_SCAN_END;
                end
            end
            S_SCAN_END: begin
                o_cmd.scan_fin = 1'b1;
                n_state        = i_sts.fin_empty ? S_DONE : S_RMW_RD;
            end
            S_RMW_RD: begin
                n_state = S_RMW_WR;
            end
            S_RMW_WR: begin
                o_cmd.rmw_wr = 1'b1;
                n_state      = i_sts.rmw_last ? S_DONE : S_RMW_RD;
            end
            S_DONE: begin
                o_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_busy)
        else $error("result strobe outside a busy request");

    a_done_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_busy)
        else $error("still busy after result strobe");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("request accepted without going busy");

endmodule

>>> src/cbra_datapath.sv
// Datapath: bitmap store, run scan, read-modify-write masking and free count.
module cbra_datapath #(
    parameter int MAP_BYTES = cbra_pkg::MAP_BYTES_DEF,
    parameter int MAX_RUN   = cbra_pkg::MAX_RUN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cbra_pkg::t_request i_request,
    input  cbra_pkg::t_dp_cmd  i_cmd,
    output cbra_pkg::t_dp_sts  o_sts,
    output cbra_pkg::t_result  o_result
);
    import cbra_pkg::*;

    localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int CW = AW + 3;
    localparam int N  = MAP_BYTES * 8;
    localparam int FW = $clog2(N + 1);
    localparam int LW = $clog2(MAX_RUN + 1);
    localparam int XW = ((CW > 10) ? CW : 10) + 2;
    localparam int WW = ((LW > 11) ? LW : 11) + 1;
    localparam logic [AW-1:0] LAST = AW'(MAP_BYTES - 1);
    localparam logic [XW-1:0] NX   = XW'(N);

    function automatic logic [3:0] f_pop(input logic [7:0] b);
        logic [3:0] n;
        n = '0;
        for (int k = 0; k < 8; k++) begin
            n = n + 4'(b[k]);
        end
        return n;
    endfunction

    t_request         r_req;
    logic [AW-1:0]    r_addr;
    logic [AW-1:0]    r_last;
    logic [XW-1:0]    r_lo;
    logic [XW-1:0]    r_hi;
    logic             r_pipe_vld;
    logic [AW-1:0]    r_pipe_addr;
    logic             r_issue_done;
    logic             r_scan_end;
    logic             r_in_run;
    logic [CW-1:0]    r_cur_start;
    logic [LW-1:0]    r_cur_len;
    logic [CW-1:0]    r_best_start;
    logic [LW-1:0]    r_best_len;
    logic             r_stop;
    logic [7:0]       r_rd_data;
    logic [CW-1:0]    r_found_start;
    logic [LW-1:0]    r_found_len;
    logic [FW-1:0]    r_free;
    logic [MAP_BYTES-1:0] r_valid;
    logic             r_rd_valid;

    logic [7:0]       ram_rdata;
    logic [7:0]       byte_q;
    logic [7:0]       wmask;
    logic [7:0]       n_wbyte;
    logic [FW-1:0]    n_free;

    logic             idx_ok;
    logic [XW-1:0]    free_lo;
    logic [XW-1:0]    free_end;
    logic [XW-1:0]    free_hi;
    logic             free_skip;
    logic             req_skip;

    logic             n_in_run;
    logic [CW-1:0]    n_cur_start;
    logic [LW-1:0]    n_cur_len;
    logic [CW-1:0]    n_best_start;
    logic [LW-1:0]    n_best_len;
    logic             n_stop;

    logic             fin_take;
    logic [CW-1:0]    fin_start;
    logic [LW-1:0]    fin_len;
    logic [XW-1:0]    fin_hi;

    cbra_ram #(
        .WIDTH (8),
        .DEPTH (MAP_BYTES)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (i_cmd.rmw_wr),
        .i_waddr (r_addr),
        .i_wdata (n_wbyte),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    assign byte_q = ram_rdata & {8{r_rd_valid}};

    assign idx_ok    = XW'(i_request.byte_index) < XW'(MAP_BYTES);
    assign free_lo   = XW'(i_request.run_start);
    assign free_end  = free_lo + XW'(i_request.run_length);
    assign free_hi   = (free_end > NX) ? NX : free_end;
    assign free_skip = (i_request.run_length == '0) || (free_lo >= NX);

    always_comb begin
        case (i_request.operation)
            OP_LOAD:  req_skip = !idx_ok;
            OP_READ:  req_skip = !idx_ok;
            OP_FREE:  req_skip = free_skip;
            default:  req_skip = 1'b0;
        endcase
    end

    always_comb begin
        n_in_run     = r_in_run;
        n_cur_start  = r_cur_start;
        n_cur_len    = r_cur_len;
        n_best_start = r_best_start;
        n_best_len   = r_best_len;
        n_stop       = 1'b0;
        for (int j = 0; j < 8; j++) begin
            if (!n_stop) begin
                if (byte_q[7-j]) begin
                    if (n_in_run && (n_cur_len > n_best_len)) begin
                        n_best_len   = n_cur_len;
                        n_best_start = n_cur_start;
                    end
                    n_in_run  = 1'b0;
                    n_cur_len = '0;
                end else begin
                    if (!n_in_run) begin
                        n_in_run    = 1'b1;
                        n_cur_start = {r_pipe_addr, 3'(j)};
                        n_cur_len   = LW'(1);
                    end else begin
                        n_cur_len = n_cur_len + 1'b1;
                    end
                    if ((WW'(n_cur_len) == WW'(r_req.request_clusters)) ||
                        (n_cur_len == LW'(MAX_RUN))) begin
                        n_stop = 1'b1;
                    end
                end
            end
        end
    end

    assign fin_take  = r_in_run && (r_cur_len > r_best_len);
    assign fin_start = fin_take ? r_cur_start : r_best_start;
    assign fin_len   = fin_take ? r_cur_len : r_best_len;
    assign fin_hi    = XW'(fin_start) + XW'(fin_len);

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            wmask[7-j] = (((XW'(r_addr) << 3) + XW'(j)) >= r_lo) &&
                         (((XW'(r_addr) << 3) + XW'(j)) < r_hi);
        end
        case (r_req.operation)
            OP_LOAD:  n_wbyte = r_req.byte_value;
            OP_ALLOC: n_wbyte = byte_q | wmask;
            default:  n_wbyte = byte_q & ~wmask;
        endcase
        n_free = r_free + FW'(f_pop(byte_q)) - FW'(f_pop(n_wbyte));
    end

    assign o_sts.req_skip  = req_skip;
    assign o_sts.scan_end  = r_scan_end;
    assign o_sts.fin_empty = (fin_len == '0);
    assign o_sts.rmw_last  = (r_addr == r_last);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free       <= FW'(N);
            r_valid      <= '0;
            r_pipe_vld   <= 1'b0;
            r_issue_done <= 1'b0;
            r_scan_end   <= 1'b0;
            r_stop       <= 1'b0;
            r_in_run     <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_pipe_vld   <= 1'b0;
                r_issue_done <= 1'b0;
                r_scan_end   <= 1'b0;
                r_stop       <= 1'b0;
                r_in_run     <= 1'b0;
            end
            if (i_cmd.scan) begin
                r_pipe_vld <= !r_issue_done;
                if (!r_issue_done) begin
                    r_issue_done <= (r_addr == LAST);
                end
                if (r_pipe_vld && !r_stop) begin
                    r_in_run   <= n_in_run;
                    r_stop     <= n_stop;
                    r_scan_end <= n_stop || (r_pipe_addr == LAST);
                end
            end
            if (i_cmd.rmw_wr) begin
                r_valid[r_addr] <= 1'b1;
                r_free          <= n_free;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_rd_valid <= r_valid[r_addr];
        if (i_cmd.capture) begin
            r_req         <= i_request;
            r_rd_data     <= '0;
            r_found_start <= '0;
            r_found_len   <= '0;
            r_cur_start   <= '0;
            r_cur_len     <= '0;
            r_best_start  <= '0;
            r_best_len    <= '0;
            case (i_request.operation)
                OP_LOAD, OP_READ: begin
                    r_addr <= AW'(i_request.byte_index);
                    r_last <= AW'(i_request.byte_index);
                end
                OP_FREE: begin
                    r_lo   <= free_lo;
                    r_hi   <= free_hi;
                    r_addr <= AW'(free_lo >> 3);
                    r_last <= AW'((free_hi - 1'b1) >> 3);
                end
                default: begin
                    r_addr <= '0;
                end
            endcase
        end
        if (i_cmd.read_cap) begin
            r_rd_data <= byte_q;
        end
        if (i_cmd.scan) begin
            if (!r_issue_done) begin
                r_pipe_addr <= r_addr;
                r_addr      <= r_addr + 1'b1;
            end
            if (r_pipe_vld && !r_stop) begin
                r_cur_start  <= n_cur_start;
                r_cur_len    <= n_cur_len;
                r_best_start <= n_best_start;
                r_best_len   <= n_best_len;
            end
        end
        if (i_cmd.scan_fin) begin
            r_found_start <= fin_start;
            r_found_len   <= fin_len;
            r_lo          <= XW'(fin_start);
            r_hi          <= fin_hi;
            r_addr        <= fin_start[CW-1:3];
            r_last        <= AW'((fin_hi - 1'b1) >> 3);
        end
        if (i_cmd.rmw_wr) begin
            r_addr <= r_addr + 1'b1;
        end
    end

    assign o_result.read_data     = r_rd_data;
    assign o_result.found_start   = 10'(r_found_start);
    assign o_result.found_length  = 6'(r_found_len);
    assign o_result.free_clusters = 11'(r_free);

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= FW'(N))
        else $error("free count above map size");

    a_write_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rmw_wr |-> (r_addr <= LAST))
        else $error("map write beyond last byte");

    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_fin |-> (fin_len <= LW'(MAX_RUN)))
        else $error("found run longer than run limit");

endmodule

>>> src/cluster_bitmap_run_allocator_core.sv
// Top level: cluster bitmap run allocator, controller plus datapath.
// Load and free: each map byte touched is read, then written (RMW_RD, RMW_WR); read: READ_A, then READ_B.
// Allocate: one map byte per cycle through the scan, then each byte of the found run is
// read and written back; one request at a time, busy high until the result strobe.
// Results appear for one cycle on o_done; the receiver cannot stall them.
// Reset clears per-byte valid bits so the map reads all free at once; free count = 8*MAP_BYTES.
module cluster_bitmap_run_allocator_core #(
    parameter int MAP_BYTES = cbra_pkg::MAP_BYTES_DEF,
    parameter int MAX_RUN   = cbra_pkg::MAX_RUN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  cbra_pkg::t_request i_request,
    output logic               busy,
    output logic               o_done,
    output cbra_pkg::t_result  o_result
);
    import cbra_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    cbra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_operation (i_request.operation),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd),
        .o_busy      (busy),
        .o_done      (o_done)
    );

    cbra_datapath #(
        .MAP_BYTES (MAP_BYTES),
        .MAX_RUN   (MAX_RUN)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_request (i_request),
        .i_cmd     (dp_cmd),
        .o_sts     (dp_sts),
        .o_result  (o_result)
    );

endmodule

>>> bench/tb_cluster_bitmap_run_allocator_core.sv
// Self-checking bench for the cluster bitmap run allocator: shadow bitmap, requests and result checks.
`timescale 1ns / 100ps

module tb_cluster_bitmap_run_allocator_core;
    import cbra_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int NUM_CLUSTERS   = MAP_BYTES_DEF * 8;
    localparam int RANDOM_ITEMS   = 1800;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 300;

    class alloc_scoreboard;
        bit [7:0]    cluster_map [MAP_BYTES_DEF];
        int          free_total;
        t_result     expected_q [$];
        int          errors;

        function new();
            foreach (cluster_map[b]) cluster_map[b] = 8'h00;
            free_total = NUM_CLUSTERS;
            errors = 0;
        endfunction

        function bit is_used(int c);
            return cluster_map[c / 8][7 - (c % 8)];
        endfunction

        function void mark(int c, bit used);
            cluster_map[c / 8][7 - (c % 8)] = used;
        endfunction

        function void find_run(int want, output int best_start, output int best_len);
            int cur_start;
            int cur_len;
            bit in_run;
            best_start = 0;
            best_len = 0;
            cur_start = 0;
            cur_len = 0;
            in_run = 1'b0;
            for (int c = 0; c < NUM_CLUSTERS; c++) begin
                if (is_used(c)) begin
                    if (in_run && cur_len > best_len) begin
                        best_len = cur_len;
                        best_start = cur_start;
                    end
                    in_run = 1'b0;
                    cur_len = 0;
                end else begin
                    if (!in_run) begin
                        in_run = 1'b1;
                        cur_start = c;
                        cur_len = 1;
                    end else begin
                        cur_len++;
                    end
                    if (cur_len == want || cur_len == MAX_RUN_DEF) break;
                end
            end
            if (in_run && cur_len > best_len) begin
                best_len = cur_len;
                best_start = cur_start;
            end
        endfunction

        function void note_request(t_request r);
            t_result exp;
            int run_first;
            int run_len;
            int c;
            exp = '0;
            case (r.operation)
                OP_LOAD: begin
                    cluster_map[r.byte_index] = r.byte_value;
                end
                OP_READ: begin
                    exp.read_data = cluster_map[r.byte_index];
                end
                OP_ALLOC: begin
                    find_run(int'(r.request_clusters), run_first, run_len);
                    for (int i = 0; i < run_len; i++) mark(run_first + i, 1'b1);
                    exp.found_start = run_first[9:0];
                    exp.found_length = run_len[5:0];
                end
                OP_FREE: begin
                    for (int i = 0; i < int'(r.run_length); i++) begin
                        c = int'(r.run_start) + i;
                        if (c >= NUM_CLUSTERS) break;
                        mark(c, 1'b0);
                    end
                end
            endcase
            free_total = 0;
            for (int k = 0; k < NUM_CLUSTERS; k++) if (!is_used(k)) free_total++;
            exp.free_clusters = free_total[10:0];
            expected_q.push_back(exp);
        endfunction

        task report(string what);
            $display("%0t mismatch: %s", $time, what);
            errors++;
        endtask

        task check_result(t_result got);
            t_result exp;
            if (expected_q.size() == 0) begin
                report($sformatf("result %h with no request outstanding", got));
                return;
            end
            exp = expected_q.pop_front();
            if (got.read_data !== exp.read_data)
                report($sformatf("read_data %h, want %h", got.read_data, exp.read_data));
            if (got.found_start !== exp.found_start)
                report($sformatf("found_start %0d, want %0d", got.found_start, exp.found_start));
            if (got.found_length !== exp.found_length)
                report($sformatf("found_length %0d, want %0d", got.found_length,
                                 exp.found_length));
            if (got.free_clusters !== exp.free_clusters)
                report($sformatf("free_clusters %0d, want %0d", got.free_clusters,
                                 exp.free_clusters));
        endtask
    endclass

    logic            i_clk;
    logic            i_rst_n;
    logic            start;
    t_request        request_bus;
    logic            busy;
    logic            done;
    t_result         result_bus;

    alloc_scoreboard sb;
    int              items_sent;
    bit              no_gap_run;

    cluster_bitmap_run_allocator_core dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_request (request_bus),
        .busy      (busy),
        .o_done    (done),
        .o_result  (result_bus)
    );

    initial begin
        i_clk = 1'b0;
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (no_gap_run || p < 45) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_request make_request(logic [1:0] op, int idx, int val, int want,
                                              int first, int len);
        t_request r;
        r.operation = op;
        r.byte_index = 7'(idx);
        r.byte_value = 8'(val);
        r.request_clusters = 11'(want);
        r.run_start = 10'(first);
        r.run_length = 6'(len);
        return r;
    endfunction

    function automatic t_request random_request();
        t_request r;
        int p;
        p = $urandom_range(0, 99);
        if (p < 30)      r.operation = OP_LOAD;
        else if (p < 45) r.operation = OP_READ;
        else if (p < 80) r.operation = OP_ALLOC;
        else             r.operation = OP_FREE;
        r.byte_index = 7'($urandom_range(0, 127));
        p = $urandom_range(0, 99);
        if (p < 40)      r.byte_value = 8'hFF;
        else if (p < 55) r.byte_value = 8'h00;
        else             r.byte_value = 8'($urandom_range(0, 255));
        p = $urandom_range(0, 99);
        if (p < 50)      r.request_clusters = 11'($urandom_range(1, 8));
        else if (p < 80) r.request_clusters = 11'($urandom_range(1, 32));
        else if (p < 85) r.request_clusters = '0;
        else             r.request_clusters = 11'($urandom_range(33, 2047));
        p = $urandom_range(0, 99);
        if (p < 20) r.run_start = 10'($urandom_range(990, 1023));
        else        r.run_start = 10'($urandom_range(0, 1023));
        p = $urandom_range(0, 99);
        if (p < 8)       r.run_length = '0;
        else if (p < 85) r.run_length = 6'($urandom_range(1, 32));
        else             r.run_length = 6'($urandom_range(33, 63));
        return r;
    endfunction

    task automatic send_request(t_request r);
        int gap;
        if (items_sent % 64 == 0) no_gap_run = ($urandom_range(0, 3) == 0);
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        request_bus <= r;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_request(r);
        items_sent++;
    endtask

    task automatic fill_map();
        t_request r;
        int hole;
        hole = ($urandom_range(0, 1) == 0) ? -1 : $urandom_range(0, 127);
        for (int b = 0; b < MAP_BYTES_DEF; b++) begin
            r = random_request();
            r.operation = OP_LOAD;
            r.byte_index = 7'(b);
            r.byte_value = (b == hole) ? 8'($urandom_range(0, 254)) : 8'hFF;
            send_request(r);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && done) sb.check_result(result_bus);
    end

    initial begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (start && !busy) || done) stall_cycles = 0;
            else stall_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        sb = new();
        items_sent = 0;
        no_gap_run = 1'b0;
        i_rst_n <= 1'b0;
        start <= 1'b0;
        request_bus <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(make_request(OP_READ,    0, 8'h5A,    9,    0,  0));
        send_request(make_request(OP_READ,  127, 8'hA5,    0, 1023, 63));
        send_request(make_request(OP_ALLOC,   3, 8'h00,    1,    7,  5));
        send_request(make_request(OP_ALLOC,   0, 8'hFF,    0,    0,  0));
        send_request(make_request(OP_ALLOC, 127, 8'hFF, 2047, 1023, 63));
        send_request(make_request(OP_ALLOC,   0, 8'h00,   40,    0,  1));
        send_request(make_request(OP_ALLOC,   0, 8'h00,   32,    0,  1));
        send_request(make_request(OP_FREE,    0, 8'h00,    5,    0,  0));
        send_request(make_request(OP_LOAD,  127, 8'hFF,    0,    0,  0));
        send_request(make_request(OP_LOAD,  126, 8'hFF,    0,    0,  0));
        send_request(make_request(OP_FREE,    0, 8'h00,    0, 1016, 63));
        send_request(make_request(OP_READ,  127, 8'h00,    0,    0,  0));
        send_request(make_request(OP_READ,  126, 8'h00,    0,    0,  0));
        send_request(make_request(OP_FREE,    0, 8'h00,    0,    2, 40));
        send_request(make_request(OP_LOAD,    0, 8'hAA,    0,    0,  0));
        send_request(make_request(OP_LOAD,    1, 8'h55,    0,    0,  0));
        send_request(make_request(OP_LOAD,    2, 8'h0F,    0,    0,  0));
        send_request(make_request(OP_ALLOC,   0, 8'h00,    3,    0,  0));
        send_request(make_request(OP_READ,    0, 8'h00,    0,    0,  0));
        send_request(make_request(OP_READ,    1, 8'h00,    0,    0,  0));
        send_request(make_request(OP_FREE,    0, 8'h00,    0, 1023,  1));
        send_request(make_request(OP_ALLOC,   0, 8'h00, 1024,    0,  0));
        send_request(make_request(OP_LOAD,    4, 8'hFF,    0,    0,  0));
        send_request(make_request(OP_ALLOC,   0, 8'h00,   33,    0,  0));
        send_request(make_request(OP_FREE,    0, 8'h00,    0,    0, 32));

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 599) == 0) fill_map();
            else send_request(random_request());
        end
        start <= 1'b0;

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
